// File: hw/rtl/rbl_pkg.sv
// ============================================================================
// rbl_pkg - shared types and constants of the RGB breathing LED generator
// Field widths, period mapping constants and mode codes.
// ============================================================================
package rbl_pkg;

    localparam int CH_N           = 3;
    localparam int TIME_W         = 32;
    localparam int POT_W          = 10;
    localparam int LVL_W          = 8;
    localparam int MODE_W         = 2;
    localparam int DEB_W          = 16;

    // period = PERIOD_MIN + pot * PERIOD_SPAN / POT_FULL, at most 5000
    localparam int PER_W          = 13;
    localparam int PERIOD_MIN     = 500;
    localparam int PERIOD_SPAN    = 4500;
    localparam int POT_FULL       = 1023;
    localparam int POT_PROD_W     = POT_W + PER_W;  // pot * 4500 fits 23 bits
    localparam int POT_STEPS      = POT_PROD_W;

    localparam int PHASE_BITS_DEF = 16;
    localparam int SINE_DEPTH_DEF = 256;
    localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(200);

    typedef enum logic [MODE_W-1:0] {
        MODE_SINE = 2'd0,
        MODE_TRI  = 2'd1,
        MODE_SYNC = 2'd2
    } t_mode;

endpackage

// File: hw/rtl/rbl_if.sv
// ============================================================================
// rbl_if - valid/ready channels of the RGB breathing LED generator
// Input word: action, time and three pot readings. Output word: levels,
// mode and press flag.
// ============================================================================
interface rbl_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [rbl_pkg::TIME_W-1:0]  time_ms;
    logic [rbl_pkg::POT_W-1:0]   pot_red;
    logic [rbl_pkg::POT_W-1:0]   pot_green;
    logic [rbl_pkg::POT_W-1:0]   pot_blue;

    modport source (output valid, action, time_ms, pot_red, pot_green, pot_blue,
                    input ready);
    modport sink   (input valid, action, time_ms, pot_red, pot_green, pot_blue,
                    output ready);
endinterface

interface rbl_out_if;
    logic                        valid;
    logic                        ready;
    logic [rbl_pkg::LVL_W-1:0]   red_level;
    logic [rbl_pkg::LVL_W-1:0]   green_level;
    logic [rbl_pkg::LVL_W-1:0]   blue_level;
    logic [rbl_pkg::MODE_W-1:0]  mode_now;
    logic                        press_accepted;

    modport source (output valid, red_level, green_level, blue_level, mode_now,
                    press_accepted, input ready);
    modport sink   (input valid, red_level, green_level, blue_level, mode_now,
                    press_accepted, output ready);
endinterface

// File: hw/rtl/rbl_div_lane.sv
// ============================================================================
// rbl_div_lane - bit-serial period and phase lane
// Restoring long division, one quotient bit per cycle: first pot*4500/1023
// for the period, then time / period carried on for PHASE_BITS fraction bits.
// ============================================================================
module rbl_div_lane #(
    parameter int PHASE_BITS = rbl_pkg::PHASE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rbl_pkg::TIME_W-1:0]   i_time,
    input  logic [rbl_pkg::POT_W-1:0]    i_pot,
    output logic                         o_done,
    output logic [PHASE_BITS-1:0]        o_phase
);

    localparam int TW         = rbl_pkg::TIME_W;
    localparam int PW         = rbl_pkg::PER_W;
    localparam int PROD_W     = rbl_pkg::POT_PROD_W;
    localparam int TIME_STEPS = TW + PHASE_BITS;
    localparam int CNT_W      = $clog2(TIME_STEPS);
    localparam int QUO_W      = (PHASE_BITS > PW) ? PHASE_BITS : PW;

    typedef enum logic [1:0] {L_IDLE, L_PER, L_SET, L_PH} t_lstate;

    t_lstate            r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [TW-1:0]      r_dvd;
    logic [PW-1:0]      r_rem;
    logic [PW-1:0]      r_dsr;
    logic [QUO_W-1:0]   r_quo;

    logic [PW:0]        w_trial;
    logic [PW:0]        w_diff;
    logic               w_ge;
    logic [PW-1:0]      n_rem;
    logic [QUO_W-1:0]   n_quo;
    logic [PROD_W-1:0]  w_pot_x;

    assign w_trial = {r_rem, r_dvd[TW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign n_rem   = w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
    assign n_quo   = {r_quo[QUO_W-2:0], w_ge};
    assign w_pot_x = PROD_W'(i_pot) * PROD_W'(rbl_pkg::PERIOD_SPAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_state <= L_PER;
                        r_cnt   <= '0;
                    end
                end
                L_PER: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(rbl_pkg::POT_STEPS - 1)) begin
                        r_state <= L_SET;
                    end
                end
                L_SET: begin
                    r_state <= L_PH;
                    r_cnt   <= '0;
                end
                L_PH: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(TIME_STEPS - 1)) begin
                        r_state <= L_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    r_dvd <= {w_pot_x, (TW - PROD_W)'(0)};
                    r_rem <= '0;
                    r_quo <= '0;
                    r_dsr <= PW'(rbl_pkg::POT_FULL);
                end
            end
            L_PER, L_PH: begin
                r_dvd <= {r_dvd[TW-2:0], 1'b0};
                r_rem <= n_rem;
                r_quo <= n_quo;
            end
            L_SET: begin
                r_dsr <= PW'(rbl_pkg::PERIOD_MIN) + r_quo[PW-1:0];
                r_dvd <= i_time;
                r_rem <= '0;
            end
            default: r_rem <= r_rem;
        endcase
    end

    // integer quotient bits have shifted out; the low bits are the fraction
    assign o_done  = r_done;
    assign o_phase = r_quo[PHASE_BITS-1:0];

endmodule

// File: hw/rtl/rbl_shape.sv
// ============================================================================
// rbl_shape - phase to PWM level
// One channel per cycle: triangle or sine table lookup, registered read.
// ============================================================================
module rbl_shape #(
    parameter int PHASE_BITS       = rbl_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = rbl_pkg::SINE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  rbl_pkg::t_mode              i_mode,
    input  logic [PHASE_BITS-1:0]       i_phase [rbl_pkg::CH_N],
    output logic                        o_done,
    output logic [rbl_pkg::LVL_W-1:0]   o_level [rbl_pkg::CH_N]
);

    localparam int LW     = rbl_pkg::LVL_W;
    localparam int CH_W   = $clog2(rbl_pkg::CH_N);
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int DEP_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int TRI_W  = PHASE_BITS + 9;
    localparam int IPR_W  = PHASE_BITS + DEP_W;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] DEPTH_64    = 64'(SINE_TABLE_DEPTH);

    // sin(pi/2 * m / depth) in Q30, quadrant-folded Taylor series
    function automatic logic [63:0] quarter_sine(input logic [63:0] m);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] sum;
        if (m >= DEPTH_64) begin
            return ONE_Q30;
        end
        a    = HALF_PI_Q30 * m / SINE_TABLE_DEPTH;
        a2   = (a * a) >> 30;
        term = a;
        sum  = a;
        term = ((term * a2) >> 30) / 64'd6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * a2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * a2) >> 30) / 64'd42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * a2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * a2) >> 30) / 64'd110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * a2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * a2) >> 30) / 64'd210;
        sum  = (sum >= term) ? sum - term : 64'd0;
        return (sum > ONE_Q30) ? ONE_Q30 : sum;
    endfunction

    function automatic logic [LW-1:0] sine_entry(input logic [63:0] idx);
        logic [63:0] u;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] s;
        logic [63:0] v;
        u   = idx * 64'd4;
        q   = u / SINE_TABLE_DEPTH;
        rem = u - q * DEPTH_64;
        s   = q[0] ? quarter_sine(DEPTH_64 - rem) : quarter_sine(rem);
        v   = q[1] ? ((ONE_Q30 - s) * 64'd255) >> 31 : ((ONE_Q30 + s) * 64'd255) >> 31;
        return v[LW-1:0];
    endfunction

    logic [LW-1:0] w_lut [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_lut
        assign w_lut[g] = sine_entry(64'(g));
    end

    logic              r_issue;
    logic [CH_W-1:0]   r_ch;
    logic              r_v1;
    logic [CH_W-1:0]   r_ch1;
    logic              r_done;
    logic [IDX_W-1:0]  r_idx;
    logic [LW-1:0]     r_tri;
    logic [LW-1:0]     r_level [rbl_pkg::CH_N];

    logic [PHASE_BITS-1:0] w_ph;
    logic [PHASE_BITS-1:0] w_h;
    logic [TRI_W-1:0]      w_tri_p;
    logic [TRI_W-1:0]      w_tri_v;
    logic [IPR_W-1:0]      w_idx_p;
    logic [IPR_W-1:0]      w_idx_v;

    assign w_ph    = i_phase[r_ch];
    // falling half: 2^PHASE_BITS - phase, which the wrap of the subtract gives
    assign w_h     = w_ph[PHASE_BITS-1] ? (PHASE_BITS'(0) - w_ph) : w_ph;
    assign w_tri_p = TRI_W'(w_h) * TRI_W'(510);
    assign w_tri_v = w_tri_p >> PHASE_BITS;
    assign w_idx_p = IPR_W'(w_ph) * IPR_W'(SINE_TABLE_DEPTH);
    assign w_idx_v = w_idx_p >> PHASE_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_ch    <= '0;
            r_v1    <= 1'b0;
            r_ch1   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_v1   <= r_issue;
            r_ch1  <= r_ch;
            if (r_issue) begin
                r_ch <= r_ch + 1'b1;
                if (r_ch == CH_W'(rbl_pkg::CH_N - 1)) begin
                    r_issue <= 1'b0;
                end
            end else if (i_start) begin
                r_issue <= 1'b1;
                r_ch    <= '0;
            end
            if (r_v1 && r_ch1 == CH_W'(rbl_pkg::CH_N - 1)) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_issue) begin
            r_idx <= w_idx_v[IDX_W-1:0];
            r_tri <= (w_tri_v > TRI_W'(255)) ? LW'(255) : w_tri_v[LW-1:0];
        end
        if (r_v1) begin
            r_level[r_ch1] <= (i_mode == rbl_pkg::MODE_TRI) ? r_tri : w_lut[r_idx];
        end
    end

    assign o_done  = r_done;
    assign o_level = r_level;

endmodule

// File: hw/rtl/rgb_breathing_led_generator.sv
// ============================================================================
// rgb_breathing_led_generator - three-channel breathing LED level generator
// Debounced mode button, pot-controlled periods, triangle or sine levels.
// ============================================================================
// Each input word carries a millisecond time, three pot readings and a tick
// or press action; each gives exactly one output word. The three bit-serial
// divider lanes run side by side: each first divides for the period, then
// sets up the period divisor, then divides the time for the phase; the
// three-channel level lookup follows, and the result is registered in the
// output word. One word is in work at a time; a new word is taken while the
// previous result waits in the output register, and an unread result holds
// back only the next result.
// debounce_ms is written through i_cfg_we/i_cfg_wdata; the user must write it
// only while idle, which the block itself does not enforce.
module rgb_breathing_led_generator #(
    parameter int PHASE_BITS       = rbl_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = rbl_pkg::SINE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rbl_pkg::DEB_W-1:0]  i_cfg_wdata,
    rbl_in_if.sink                     i_in,
    rbl_out_if.source                  o_out
);

    localparam int CH_N = rbl_pkg::CH_N;
    localparam int TW   = rbl_pkg::TIME_W;
    localparam int LW   = rbl_pkg::LVL_W;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SHAPE, S_OUT} t_state;

    t_state                    r_state;
    rbl_pkg::t_mode            r_mode;
    logic [TW-1:0]             r_last_press;
    logic [rbl_pkg::DEB_W-1:0] r_debounce;
    logic                      r_lane_go;
    logic                      r_shape_go;
    logic                      r_out_valid;
    logic [TW-1:0]             r_time;
    logic [rbl_pkg::POT_W-1:0] r_pot [CH_N];
    logic                      r_acc;
    logic [LW-1:0]             r_out_lvl [CH_N];
    rbl_pkg::t_mode            r_out_mode;
    logic                      r_out_acc;

    logic                      w_accept;
    logic [TW-1:0]             w_dt;
    logic                      w_press_ok;
    rbl_pkg::t_mode            n_mode;
    logic                      w_load;
    logic [CH_N-1:0]           w_lane_done;
    logic [PHASE_BITS-1:0]     w_phase [CH_N];
    logic                      w_shape_done;
    logic [LW-1:0]             w_level [CH_N];

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_dt       = i_in.time_ms - r_last_press;
    assign w_press_ok = i_in.action && (w_dt > TW'(r_debounce));
    assign w_load     = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_mode = r_mode;
        if (w_press_ok) begin
            unique case (r_mode)
                rbl_pkg::MODE_SINE: n_mode = rbl_pkg::MODE_TRI;
                rbl_pkg::MODE_TRI:  n_mode = rbl_pkg::MODE_SYNC;
                default:            n_mode = rbl_pkg::MODE_SINE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= rbl_pkg::MODE_SINE;
            r_last_press <= '0;
            r_debounce   <= rbl_pkg::DEBOUNCE_RST;
            r_lane_go    <= 1'b0;
            r_shape_go   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_lane_go  <= 1'b0;
            r_shape_go <= 1'b0;
            if (i_cfg_we) begin
                r_debounce <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state   <= S_DIV;
                        r_lane_go <= 1'b1;
                        r_mode    <= n_mode;
                        if (w_press_ok) begin
                            r_last_press <= i_in.time_ms;
                        end
                    end
                end
                S_DIV: begin
                    if (&w_lane_done) begin
                        r_state    <= S_SHAPE;
                        r_shape_go <= 1'b1;
                    end
                end
                S_SHAPE: begin
                    if (w_shape_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // in synced mode the red pot drives every channel
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time   <= i_in.time_ms;
            r_acc    <= w_press_ok;
            r_pot[0] <= i_in.pot_red;
            r_pot[1] <= (n_mode == rbl_pkg::MODE_SYNC) ? i_in.pot_red : i_in.pot_green;
            r_pot[2] <= (n_mode == rbl_pkg::MODE_SYNC) ? i_in.pot_red : i_in.pot_blue;
        end
        if (w_load) begin
            r_out_lvl  <= w_level;
            r_out_mode <= r_mode;
            r_out_acc  <= r_acc;
        end
    end

    for (genvar g = 0; g < CH_N; g++) begin : g_lane
        rbl_div_lane #(
            .PHASE_BITS (PHASE_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_lane_go),
            .i_time  (r_time),
            .i_pot   (r_pot[g]),
            .o_done  (w_lane_done[g]),
            .o_phase (w_phase[g])
        );
    end

    rbl_shape #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_shape_go),
        .i_mode  (r_mode),
        .i_phase (w_phase),
        .o_done  (w_shape_done),
        .o_level (w_level)
    );

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.red_level      = r_out_lvl[0];
    assign o_out.green_level    = r_out_lvl[1];
    assign o_out.blue_level     = r_out_lvl[2];
    assign o_out.mode_now       = r_out_mode;
    assign o_out.press_accepted = r_out_acc;

`ifndef SYNTHESIS
    a_one_word_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("input taken while a word is in work");

    a_press_moves_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_press_ok) |=> (r_mode != $past(r_mode)))
        else $error("accepted press did not advance the mode");

    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lane_done != '0) |-> (&w_lane_done))
        else $error("divider lanes out of step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_out.ready) |=> (r_state == S_OUT))
        else $error("result overwrote a waiting output word");
`endif

endmodule
